FILE: rtl/assert_macros.svh
// assertion helpers, clocked on clk_i and disabled during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/pdsob_pkg.sv
package pdsob_pkg;

  localparam int OFFSET_BITS = 16;
  localparam int DIST_W      = 16;
  localparam int STEP_W      = 16;
  localparam int TURN_W      = 16;
  localparam int INT_W       = 16;
  localparam int KP_W        = 10;
  localparam int KD_W        = 20;
  localparam int CFG_DATA_W  = 20;
  localparam int CFG_IDX_W   = 3;

  localparam int DIFF_W  = OFFSET_BITS + 1;
  localparam int PTERM_W = KP_W + 1 + OFFSET_BITS;
  localparam int DPROD_W = KD_W + 1 + DIFF_W;
  localparam int DMAG_W  = DPROD_W - 1;
  localparam int DTERM_W = DMAG_W + 1;
  localparam int RAW_W   = DTERM_W + 2;
  localparam int CNT_W   = $clog2(DMAG_W + 1);

  localparam logic [TURN_W-1:0] TURN_CENTER = TURN_W'(1500);

  localparam logic [DIST_W-1:0] RST_DIST_THR = DIST_W'(60);
  localparam logic [KP_W-1:0]   RST_KP       = KP_W'(30);
  localparam logic [KD_W-1:0]   RST_KD_MS    = KD_W'(20000);
  localparam logic [TURN_W-1:0] RST_MIN_TURN = TURN_W'(1100);
  localparam logic [TURN_W-1:0] RST_MAX_TURN = TURN_W'(1900);
  localparam logic [INT_W-1:0]  RST_SLOW     = INT_W'(1500);
  localparam logic [INT_W-1:0]  RST_CRUISE   = INT_W'(1700);

  localparam logic [CFG_IDX_W-1:0] CFG_DIST_THR = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_KP       = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_KD_MS    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_TURN = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TURN = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW     = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] CFG_CRUISE   = CFG_IDX_W'(6);

  typedef struct packed {
    logic [DIST_W-1:0] brake_dist;
    logic [KP_W-1:0]   kp;
    logic [KD_W-1:0]   kd_ms;
    logic [TURN_W-1:0] turn_lo;
    logic [TURN_W-1:0] turn_hi;
    logic [INT_W-1:0]  slow_intensity;
    logic [INT_W-1:0]  cruise_intensity;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic div_start;
    logic sum;
    logic clamp;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic brake;
    logic step_zero;
    logic div_busy;
  } dp_status_t;

endpackage

FILE: rtl/pdsob_in_if.sv
interface pdsob_in_if;
  logic                                   valid;
  logic                                   ready;
  logic        [pdsob_pkg::DIST_W-1:0]      distance;
  logic signed [pdsob_pkg::OFFSET_BITS-1:0] lane_offset;
  logic        [pdsob_pkg::STEP_W-1:0]      step_ms;
  logic                                   slow_req;
  logic                                   stop_request;

  modport source (
    output valid, distance, lane_offset, step_ms, slow_req, stop_request,
    input  ready
  );
  modport sink (
    input  valid, distance, lane_offset, step_ms, slow_req, stop_request,
    output ready
  );
endinterface

FILE: rtl/pdsob_out_if.sv
interface pdsob_out_if;
  logic                          valid;
  logic                          ready;
  logic [pdsob_pkg::TURN_W-1:0]  turn;
  logic [pdsob_pkg::INT_W-1:0]   intensity;
  logic                          braking;

  modport source (
    output valid, turn, intensity, braking,
    input  ready
  );
  modport sink (
    input  valid, turn, intensity, braking,
    output ready
  );
endinterface

FILE: rtl/pdsob_div.sv
module pdsob_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [pdsob_pkg::DMAG_W-1:0]    dividend_i,
  input  logic [pdsob_pkg::STEP_W-1:0]    divisor_i,
  output logic                            busy_o,
  output logic [pdsob_pkg::DMAG_W-1:0]    quotient_o
);

  logic [pdsob_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [pdsob_pkg::STEP_W-1:0] rem_q, rem_d;
  logic [pdsob_pkg::DMAG_W-1:0] quo_q, quo_d;
  logic [pdsob_pkg::STEP_W:0]   rem_sh;
  logic [pdsob_pkg::STEP_W:0]   rem_sub;
  logic                         fits;

  // one quotient bit per cycle, restoring
  assign rem_sh  = {rem_q, quo_q[pdsob_pkg::DMAG_W-1]};
  assign rem_sub = rem_sh - {1'b0, divisor_i};
  assign fits    = rem_sh >= {1'b0, divisor_i};

  always_comb begin
    cnt_d = cnt_q;
    rem_d = rem_q;
    quo_d = quo_q;
    if (start_i) begin
      cnt_d = pdsob_pkg::CNT_W'(pdsob_pkg::DMAG_W);
      rem_d = '0;
      quo_d = dividend_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - pdsob_pkg::CNT_W'(1);
      rem_d = fits ? rem_sub[pdsob_pkg::STEP_W-1:0] : rem_sh[pdsob_pkg::STEP_W-1:0];
      quo_d = {quo_q[pdsob_pkg::DMAG_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign busy_o     = cnt_q != '0;
  assign quotient_o = quo_q;

endmodule

FILE: rtl/pdsob_dp.sv
module pdsob_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pdsob_pkg::cfg_t                     cfg_i,
  input  pdsob_pkg::dp_cmd_t                  cmd_i,
  output pdsob_pkg::dp_status_t               status_o,
  input  logic        [pdsob_pkg::DIST_W-1:0]      distance_i,
  input  logic signed [pdsob_pkg::OFFSET_BITS-1:0] lane_offset_i,
  input  logic        [pdsob_pkg::STEP_W-1:0]      step_ms_i,
  input  logic                                slow_req_i,
  input  logic                                stop_request_i,
  output logic        [pdsob_pkg::TURN_W-1:0]      turn_o,
  output logic        [pdsob_pkg::INT_W-1:0]       intensity_o,
  output logic                                braking_o
);

  logic        [pdsob_pkg::DIST_W-1:0]      dist_q;
  logic signed [pdsob_pkg::OFFSET_BITS-1:0] offset_q;
  logic        [pdsob_pkg::STEP_W-1:0]      step_q;
  logic                                     slow_q;
  logic                                     stop_q;

  logic signed [pdsob_pkg::OFFSET_BITS-1:0] last_q;
  logic        [pdsob_pkg::TURN_W-1:0]      held_q;

  logic signed [pdsob_pkg::DIFF_W-1:0]      diff;
  logic signed [pdsob_pkg::PTERM_W-1:0]     pterm_d, pterm_q;
  logic signed [pdsob_pkg::DPROD_W-1:0]     dprod_d, dprod_q;
  logic signed [pdsob_pkg::DPROD_W-1:0]     dabs;
  logic                                     dneg;
  logic                                     div_busy;
  logic        [pdsob_pkg::DMAG_W-1:0]      quo;
  logic signed [pdsob_pkg::DTERM_W-1:0]     dterm;
  logic signed [pdsob_pkg::RAW_W-1:0]       raw_d, raw_q;
  logic signed [pdsob_pkg::RAW_W-1:0]       min_s, max_s;
  logic        [pdsob_pkg::TURN_W-1:0]      clamp_d, clamp_q;
  logic                                     brake;

  logic        [pdsob_pkg::TURN_W-1:0]      turn_q;
  logic        [pdsob_pkg::INT_W-1:0]       intensity_q;
  logic                                     braking_q;

  assign brake = (dist_q < cfg_i.brake_dist) || stop_q;

  assign diff    = pdsob_pkg::DIFF_W'(offset_q) - pdsob_pkg::DIFF_W'(last_q);
  assign pterm_d = pdsob_pkg::PTERM_W'($signed({1'b0, cfg_i.kp}))
                 * pdsob_pkg::PTERM_W'(offset_q);
  assign dprod_d = pdsob_pkg::DPROD_W'($signed({1'b0, cfg_i.kd_ms}))
                 * pdsob_pkg::DPROD_W'(diff);

  assign dneg = dprod_q[pdsob_pkg::DPROD_W-1];
  assign dabs = dneg ? -dprod_q : dprod_q;

  pdsob_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dabs[pdsob_pkg::DMAG_W-1:0]),
    .divisor_i  (step_q),
    .busy_o     (div_busy),
    .quotient_o (quo)
  );

  // quotient truncates toward zero, no derivative on a zero step
  always_comb begin
    dterm = $signed({1'b0, quo});
    if (dneg) begin
      dterm = -dterm;
    end
    if (step_q == '0) begin
      dterm = '0;
    end
  end

  assign raw_d = pdsob_pkg::RAW_W'(pterm_q) + pdsob_pkg::RAW_W'(dterm)
               + $signed(pdsob_pkg::RAW_W'(pdsob_pkg::TURN_CENTER));

  assign min_s = $signed(pdsob_pkg::RAW_W'(cfg_i.turn_lo));
  assign max_s = $signed(pdsob_pkg::RAW_W'(cfg_i.turn_hi));

  always_comb begin
    if (raw_q < min_s) begin
      clamp_d = cfg_i.turn_lo;
    end else if (raw_q > max_s) begin
      clamp_d = cfg_i.turn_hi;
    end else begin
      clamp_d = raw_q[pdsob_pkg::TURN_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dist_q   <= distance_i;
      offset_q <= lane_offset_i;
      step_q   <= step_ms_i;
      slow_q   <= slow_req_i;
      stop_q   <= stop_request_i;
    end
    if (cmd_i.mul) begin
      pterm_q <= pterm_d;
      dprod_q <= dprod_d;
    end
    if (cmd_i.sum) begin
      raw_q <= raw_d;
    end
    if (cmd_i.clamp) begin
      clamp_q <= clamp_d;
    end
    if (cmd_i.finish) begin
      turn_q      <= brake ? held_q : clamp_q;
      intensity_q <= brake ? '0 : (slow_q ? cfg_i.slow_intensity : cfg_i.cruise_intensity);
      braking_q   <= brake;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
      held_q <= pdsob_pkg::TURN_CENTER;
    end else if (cmd_i.finish) begin
      last_q <= offset_q;
      if (!brake) begin
        held_q <= clamp_q;
      end
    end
  end

  assign status_o.brake     = brake;
  assign status_o.step_zero = step_q == '0;
  assign status_o.div_busy  = div_busy;

  assign turn_o      = turn_q;
  assign intensity_o = intensity_q;
  assign braking_o   = braking_q;

endmodule

FILE: rtl/pdsob_ctrl.sv
module pdsob_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  pdsob_pkg::dp_status_t status_i,
  output pdsob_pkg::dp_cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_DIVGO = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_SUM   = 3'd4;
  localparam logic [2:0] S_CLAMP = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q & ~out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.mul = 1'b1;
        state_d   = status_i.brake ? S_DONE : S_DIVGO;
      end
      S_DIVGO: begin
        if (status_i.step_zero) begin
          state_d = S_SUM;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end
      end
      S_DIV: begin
        if (!status_i.div_busy) begin
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_CLAMP;
      end
      S_CLAMP: begin
        cmd_o.clamp = 1'b1;
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/pd_steering_with_obstacle_brake_top.sv
// PD steering controller with obstacle brake, one item in flight at a time. A steered
// item passes through the multiply, divider start, serial divider for the derivative
// term (37 quotient bits, one per cycle), sum, clamp and hand-off steps before
// the next ready. A braking item goes from the multiply to the hand-off; an item with
// a zero time step skips the divider. The result sits in an output register, so the
// next item is accepted while it waits to be taken; that item then holds in its last
// step until the waiting result is taken. Configuration registers are written through
// cfg_we_i / cfg_idx_i / cfg_data_i; the user must write them only while the block is
// idle, which the block does not enforce. Unknown indexes are ignored.
`include "assert_macros.svh"

module pd_steering_with_obstacle_brake_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [pdsob_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [pdsob_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  pdsob_in_if.sink                             in_i,
  pdsob_out_if.source                          out_o
);

  pdsob_pkg::cfg_t       cfg_q;
  pdsob_pkg::dp_cmd_t    cmd;
  pdsob_pkg::dp_status_t status;
  logic                  turn_chk;
  logic                  turn_in_lim;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.brake_dist       <= pdsob_pkg::RST_DIST_THR;
      cfg_q.kp               <= pdsob_pkg::RST_KP;
      cfg_q.kd_ms            <= pdsob_pkg::RST_KD_MS;
      cfg_q.turn_lo          <= pdsob_pkg::RST_MIN_TURN;
      cfg_q.turn_hi          <= pdsob_pkg::RST_MAX_TURN;
      cfg_q.slow_intensity   <= pdsob_pkg::RST_SLOW;
      cfg_q.cruise_intensity <= pdsob_pkg::RST_CRUISE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pdsob_pkg::CFG_DIST_THR: cfg_q.brake_dist     <= cfg_data_i[pdsob_pkg::DIST_W-1:0];
        pdsob_pkg::CFG_KP:       cfg_q.kp             <= cfg_data_i[pdsob_pkg::KP_W-1:0];
        pdsob_pkg::CFG_KD_MS:    cfg_q.kd_ms          <= cfg_data_i[pdsob_pkg::KD_W-1:0];
        pdsob_pkg::CFG_MIN_TURN: cfg_q.turn_lo        <= cfg_data_i[pdsob_pkg::TURN_W-1:0];
        pdsob_pkg::CFG_MAX_TURN: cfg_q.turn_hi        <= cfg_data_i[pdsob_pkg::TURN_W-1:0];
        pdsob_pkg::CFG_SLOW:     cfg_q.slow_intensity <= cfg_data_i[pdsob_pkg::INT_W-1:0];
        pdsob_pkg::CFG_CRUISE: begin
          cfg_q.cruise_intensity <= cfg_data_i[pdsob_pkg::INT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  pdsob_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pdsob_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .cmd_i          (cmd),
    .status_o       (status),
    .distance_i     (in_i.distance),
    .lane_offset_i  (in_i.lane_offset),
    .step_ms_i      (in_i.step_ms),
    .slow_req_i     (in_i.slow_req),
    .stop_request_i (in_i.stop_request),
    .turn_o         (out_o.turn),
    .intensity_o    (out_o.intensity),
    .braking_o      (out_o.braking)
  );

  assign turn_chk    = out_o.valid && !out_o.braking && (cfg_q.turn_lo <= cfg_q.turn_hi);
  assign turn_in_lim = (out_o.turn >= cfg_q.turn_lo) && (out_o.turn <= cfg_q.turn_hi);

  `ASSERT_NXT(a_one_item, in_i.valid && in_i.ready, !in_i.ready, "item taken while busy")
  `ASSERT_IMP(a_brake_zero, out_o.valid && out_o.braking, ~|out_o.intensity, "brake intensity")
  `ASSERT_IMP(a_turn_range, turn_chk, turn_in_lim, "turn outside limits")

endmodule
